// ----- hdl/rtpc_pkg.sv -----
// Shared types, constants and the arctangent table for the rectangular-to-polar converter.
package rtpc_pkg;

  localparam int DATA_WIDTH         = 16;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int CORDIC_STAGES_MAX  = 32;
  localparam int GUARD_BITS         = 8;
  localparam int XY_WIDTH           = DATA_WIDTH + GUARD_BITS + 3;
  localparam int ANG_WIDTH          = 32;
  localparam int IDX_WIDTH          = $clog2(CORDIC_STAGES_MAX);
  localparam int GAIN_WIDTH         = 24;
  localparam logic [GAIN_WIDTH-1:0] GAIN_Q24  = 24'd10188014;
  localparam logic [ANG_WIDTH-1:0]  HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] real_part;
    logic signed [DATA_WIDTH-1:0] imag_part;
  } rtpc_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] magnitude;
    logic [DATA_WIDTH-1:0] phase_turns;
  } rtpc_out_t;

  typedef struct packed {
    logic                       zero;
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic [ANG_WIDTH-1:0]       z;
  } rtpc_vec_t;

  function automatic logic [ANG_WIDTH-1:0] atan_turns(input logic [IDX_WIDTH-1:0] idx);
    logic [ANG_WIDTH-1:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2F9;
      5'd15:   r = 32'h0000_517C;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A2F;
      5'd19:   r = 32'h0000_0517;
      5'd20:   r = 32'h0000_028B;
      5'd21:   r = 32'h0000_0145;
      5'd22:   r = 32'h0000_00A2;
      5'd23:   r = 32'h0000_0051;
      5'd24:   r = 32'h0000_0028;
      5'd25:   r = 32'h0000_0014;
      5'd26:   r = 32'h0000_000A;
      5'd27:   r = 32'h0000_0005;
      5'd28:   r = 32'h0000_0002;
      5'd29:   r = 32'h0000_0001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/rtpc_prep.sv -----
// Input stage: scale by guard bits, fold the left half plane, flag zero input.
module rtpc_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtpc_pkg::rtpc_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtpc_pkg::rtpc_vec_t  out_data
);

  logic                                     valid_r;
  rtpc_pkg::rtpc_vec_t                      data_r;
  rtpc_pkg::rtpc_vec_t                      data_nxt;
  logic signed [rtpc_pkg::XY_WIDTH-1:0]     x_ext;
  logic signed [rtpc_pkg::XY_WIDTH-1:0]     y_ext;
  logic                                     adv;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    x_ext = rtpc_pkg::XY_WIDTH'(in_data.real_part) <<< rtpc_pkg::GUARD_BITS;
    y_ext = rtpc_pkg::XY_WIDTH'(in_data.imag_part) <<< rtpc_pkg::GUARD_BITS;
    data_nxt.zero = (in_data.real_part == '0) && (in_data.imag_part == '0);
    if (in_data.real_part[rtpc_pkg::DATA_WIDTH-1]) begin
      data_nxt.x = -x_ext;
      data_nxt.y = -y_ext;
      data_nxt.z = rtpc_pkg::HALF_TURN;
    end else begin
      data_nxt.x = x_ext;
      data_nxt.y = y_ext;
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hdl/rtpc_stage.sv -----
// One registered CORDIC vectoring iteration.
module rtpc_stage #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtpc_pkg::rtpc_vec_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtpc_pkg::rtpc_vec_t  out_data
);

  logic                                 valid_r;
  rtpc_pkg::rtpc_vec_t                  data_r;
  rtpc_pkg::rtpc_vec_t                  data_nxt;
  logic signed [rtpc_pkg::XY_WIDTH-1:0] dx;
  logic signed [rtpc_pkg::XY_WIDTH-1:0] dy;
  logic [rtpc_pkg::ANG_WIDTH-1:0]       angle;
  logic                                 adv;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;
  assign angle    = rtpc_pkg::atan_turns(rtpc_pkg::IDX_WIDTH'(IDX));

  always_comb begin
    dx = in_data.y >>> IDX;
    dy = in_data.x >>> IDX;
    data_nxt.zero = in_data.zero;
    if (!in_data.y[rtpc_pkg::XY_WIDTH-1]) begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + angle;
    end else begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hdl/rtpc_post.sv -----
// Output stages: gain multiply, then round, saturate and register the item.
module rtpc_post (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtpc_pkg::rtpc_vec_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtpc_pkg::rtpc_out_t  out_data
);

  localparam int XU_WIDTH   = rtpc_pkg::XY_WIDTH - 1;
  localparam int PROD_WIDTH = XU_WIDTH + rtpc_pkg::GAIN_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 1;
  localparam int RND_SHIFT  = 32;
  localparam int MAGF_WIDTH = SUM_WIDTH - RND_SHIFT;
  localparam int DW         = rtpc_pkg::DATA_WIDTH;

  logic                             mul_valid_r;
  logic [PROD_WIDTH-1:0]            prod_r;
  logic [rtpc_pkg::ANG_WIDTH-1:0]   z_r;
  logic                             zero_r;
  logic [PROD_WIDTH-1:0]            prod_nxt;
  logic                             out_valid_r;
  rtpc_pkg::rtpc_out_t              out_data_r;
  rtpc_pkg::rtpc_out_t              out_data_nxt;
  logic [SUM_WIDTH-1:0]             rnd_sum;
  logic [MAGF_WIDTH-1:0]            mag_full;
  logic [rtpc_pkg::ANG_WIDTH-1:0]   z_rnd;
  logic                             out_adv;
  logic                             mul_adv;

  assign out_adv  = !out_valid_r || !out_stall;
  assign mul_adv  = !mul_valid_r || out_adv;
  assign in_ready = mul_adv;

  assign prod_nxt = PROD_WIDTH'(in_data.x[XU_WIDTH-1:0]) * PROD_WIDTH'(rtpc_pkg::GAIN_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_adv) begin
      mul_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_adv && in_valid) begin
      prod_r <= prod_nxt;
      z_r    <= in_data.z;
      zero_r <= in_data.zero;
    end
  end

  always_comb begin
    rnd_sum  = SUM_WIDTH'(prod_r) + (SUM_WIDTH'(1) << (RND_SHIFT - 1));
    mag_full = rnd_sum[SUM_WIDTH-1:RND_SHIFT];
    z_rnd    = z_r + (rtpc_pkg::ANG_WIDTH'(1) << (rtpc_pkg::ANG_WIDTH - DW - 1));
    if (zero_r) begin
      out_data_nxt.magnitude   = '0;
      out_data_nxt.phase_turns = '0;
    end else begin
      if (|mag_full[MAGF_WIDTH-1:DW]) begin
        out_data_nxt.magnitude = '1;
      end else begin
        out_data_nxt.magnitude = mag_full[DW-1:0];
      end
      out_data_nxt.phase_turns = z_rnd[rtpc_pkg::ANG_WIDTH-1:rtpc_pkg::ANG_WIDTH-DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mul_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/rect_to_polar_converter_top.sv -----
// Top level of the pipelined CORDIC rectangular-to-polar converter.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | rtpc_in_t  (real_part, imag_part)
//   out     | output    | out_valid/out_stall | rtpc_out_t (magnitude, phase_turns)
//
// One item per cycle sustained while out_stall is low. The path runs through the input
// stage register, one register per CORDIC iteration, the gain multiply register
// and the output register.
// rst_n clears all valid bits; no state survives between items.
// out_stall holds the output register; earlier stages keep filling bubbles and
// in_stall rises only when every stage holds an item.
module rect_to_polar_converter_top #(
  parameter int CORDIC_STAGES = rtpc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtpc_pkg::rtpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rtpc_pkg::rtpc_out_t out_data
);

  logic                vld   [0:CORDIC_STAGES];
  logic                rdy   [0:CORDIC_STAGES];
  rtpc_pkg::rtpc_vec_t vec   [0:CORDIC_STAGES];
  logic                in_ready;

  assign in_stall = !in_ready;

  rtpc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (vec[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    rtpc_stage #(
      .IDX (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (vec[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (vec[k+1])
    );
  end

  rtpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld[CORDIC_STAGES]),
    .in_ready  (rdy[CORDIC_STAGES]),
    .in_data   (vec[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/rtpc_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module rtpc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rtpc_pkg::rtpc_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rtpc_pkg::rtpc_out_t out_data
);

  localparam logic [rtpc_pkg::DATA_WIDTH-1:0] MAG_LIMIT = 16'd46341;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.magnitude <= MAG_LIMIT)
    else $error("magnitude out of range");

  a_no_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rect_to_polar_converter_top rtpc_checker u_rtpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_rect_to_polar_converter_top.sv -----
// Self-checking testbench for the CORDIC rectangular-to-polar converter.
`timescale 1ns / 100ps

module tb_rect_to_polar_converter_top;

  localparam int STAGES      = rtpc_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY     = STAGES + 3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_ITEMS  = 500;
  localparam longint unsigned GAIN = 64'd10188014;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rtpc_pkg::rtpc_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rtpc_pkg::rtpc_out_t out_data;

  rtpc_pkg::rtpc_in_t  sample_q[$];
  rtpc_pkg::rtpc_out_t polar_q[$];
  bit        in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  int        mismatches = 0;

  logic [31:0] atan_lut [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  rect_to_polar_converter_top #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rtpc_pkg::rtpc_out_t polar_of(rtpc_pkg::rtpc_in_t s);
    longint              xv;
    longint              yv;
    longint              dx;
    longint              dy;
    logic [31:0]         acc;
    logic [31:0]         rounded;
    longint unsigned     prod;
    longint unsigned     mag;
    rtpc_pkg::rtpc_out_t r;
    r = '0;
    if (s.real_part == 0 && s.imag_part == 0) begin
      return r;
    end
    xv = s.real_part;
    yv = s.imag_part;
    xv = xv * 256;
    yv = yv * 256;
    acc = '0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      acc = rtpc_pkg::HALF_TURN;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv = xv + dx;
        yv = yv - dy;
        acc = acc + atan_lut[i];
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        acc = acc - atan_lut[i];
      end
    end
    prod = longint'(xv);
    prod = prod * GAIN;
    mag = (prod + 64'h8000_0000) >> 32;
    if (mag > 64'hFFFF) begin
      mag = 64'hFFFF;
    end
    rounded = acc + 32'h8000;
    r.magnitude = mag[15:0];
    r.phase_turns = rounded[31:16];
    return r;
  endfunction

  function automatic rtpc_pkg::rtpc_in_t random_sample();
    rtpc_pkg::rtpc_in_t s;
    int                 pick;
    pick = $urandom_range(99);
    s.real_part = 16'($urandom);
    s.imag_part = 16'($urandom);
    if (pick < 15) begin
      s.real_part = 16'($urandom_range(32) - 16);
      s.imag_part = 16'($urandom_range(32) - 16);
    end else if (pick < 25) begin
      if ($urandom_range(1) == 1) begin
        s.real_part = '0;
      end else begin
        s.imag_part = '0;
      end
    end else if (pick < 35) begin
      s.real_part = ($urandom_range(1) == 1) ? 16'(32767 - $urandom_range(3))
                                             : 16'(32768 + $urandom_range(3));
    end else if (pick < 42) begin
      s.imag_part = 16'($urandom_range(2) - 1);
    end
    return s;
  endfunction

  function automatic rtpc_pkg::rtpc_in_t make_sample(int re, int im);
    rtpc_pkg::rtpc_in_t s;
    s.real_part = 16'(re);
    s.imag_part = 16'(im);
    return s;
  endfunction

  task automatic enqueue(rtpc_pkg::rtpc_in_t s);
    sample_q.insert(sample_q.size(), s);
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid) @(negedge clk);
    while (polar_q.size() != 0) @(negedge clk);
  endtask

  // driver: advance on accept, idle at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, plus one long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    rtpc_pkg::rtpc_out_t want;
    bit                  out_taken;
    in_taken  = in_valid && !in_stall && rst_n;
    out_taken = out_valid && !out_stall && rst_n;
    if (in_taken) begin
      polar_q.insert(polar_q.size(), polar_of(in_data));
    end
    if (out_taken) begin
      if (polar_q.size() == 0) begin
        $error("unexpected result: magnitude %0d phase_turns %0d",
               out_data.magnitude, out_data.phase_turns);
        mismatches++;
      end else begin
        want = polar_q.pop_front();
        if (out_data.magnitude !== want.magnitude) begin
          $error("magnitude: expected %0d, actual %0d", want.magnitude, out_data.magnitude);
          mismatches++;
        end
        if (out_data.phase_turns !== want.phase_turns) begin
          $error("phase_turns: expected %0d, actual %0d",
                 want.phase_turns, out_data.phase_turns);
          mismatches++;
        end
      end
    end
    if (rst_n) begin
      if (in_taken || out_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 86;
    enqueue(make_sample(0, 0));
    enqueue(make_sample(32767, 0));
    enqueue(make_sample(-32768, 0));
    enqueue(make_sample(0, 32767));
    enqueue(make_sample(0, -32768));
    enqueue(make_sample(32767, 32767));
    enqueue(make_sample(-32768, -32768));
    enqueue(make_sample(-32768, 32767));
    enqueue(make_sample(32767, -32768));
    enqueue(make_sample(1, 0));
    enqueue(make_sample(-1, 0));
    enqueue(make_sample(0, 1));
    enqueue(make_sample(0, -1));
    enqueue(make_sample(-1, -1));
    enqueue(make_sample(1, -1));
    enqueue(make_sample(-1, 1));
    enqueue(make_sample(-32768, 1));
    enqueue(make_sample(-32768, -1));
    enqueue(make_sample(32767, -1));
    enqueue(make_sample(20000, -3));
    enqueue(make_sample(-5, 32767));
    for (int i = 0; i < RAND_ITEMS; i++) enqueue(random_sample());
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 13;
    for (int i = 0; i < RAND_ITEMS; i++) enqueue(random_sample());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) enqueue(random_sample());
    wait_drained();

    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && polar_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
